// ===== rtl/core/hbl_pkg.sv =====
// Shared types and constants for the HSV breathing LED color engine.
package hbl_pkg;

    localparam int HBL_FRACTION_BITS = 16;
    localparam int HBL_CFG_IDX_W     = 8;

    localparam logic [HBL_CFG_IDX_W-1:0] HBL_REG_STEP  = 8'd0;
    localparam logic [HBL_CFG_IDX_W-1:0] HBL_REG_FLOOR = 8'd1;

    localparam logic [15:0] HBL_STEP_RESET  = 16'd655;
    localparam logic [15:0] HBL_FLOOR_RESET = 16'd655;

    localparam logic [7:0] HBL_DEN_255  = 8'd255;
    localparam logic [7:0] HBL_HALF_255 = 8'd127;

    typedef struct packed {
        logic        mode;
        logic [23:0] color;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       rising;
    } t_out_word;

endpackage

// ===== rtl/core/hbl_div.sv =====
// Bit-serial restoring divider: wide dividend by an 8-bit divisor, one bit per cycle.
module hbl_div #(
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [7:0]    i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [7:0]    o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [7:0]    r_r;
    logic [7:0]    r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [8:0] w_trial;
    logic       w_ge;
    logic [8:0] w_nr;

    always_comb begin
        w_trial = {r_r, r_q[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_d});
        w_nr    = w_ge ? (w_trial - {1'b0, r_d}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], w_ge};
                r_r   <= w_nr[7:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

endmodule

// ===== rtl/core/hbl_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module hbl_mul #(
    parameter int W = 17
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [2*W-1:0] o_prod
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_hi;
    logic [W-1:0]  r_lo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0] w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[W:1];
                r_lo  <= {w_sum[0], r_lo[W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// ===== rtl/core/hsv_breathing_led_color_top.sv =====
// HSV breathing LED color engine: sequencer, state and config registers.
// One word in gives one word out. A load word stores the color and its peak
// brightness with one serial divide. A tick word runs HSV conversion, the
// brightness step and the conversion back to RGB through a bit-serial divider
// (up to four divides of F+8 bits, fewer for a gray or black color) and a
// bit-serial multiplier (five products of F+1 bits). A new word is taken while
// the previous result still waits at the output register. Config writes are
// always taken.
module hsv_breathing_led_color_top #(
    parameter int FRACTION_BITS = hbl_pkg::HBL_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hbl_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hbl_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hbl_pkg::HBL_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    localparam int F  = FRACTION_BITS;
    localparam int DW = F + 8;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PEAK = 4'd1;
    localparam logic [3:0] S_HUE  = 4'd2;
    localparam logic [3:0] S_FRAC = 4'd3;
    localparam logic [3:0] S_SAT  = 4'd4;
    localparam logic [3:0] S_VAL  = 4'd5;
    localparam logic [3:0] S_STEP = 4'd6;
    localparam logic [3:0] S_M1   = 4'd7;
    localparam logic [3:0] S_M2   = 4'd8;
    localparam logic [3:0] S_MP   = 4'd9;
    localparam logic [3:0] S_MQ   = 4'd10;
    localparam logic [3:0] S_MT   = 4'd11;
    localparam logic [3:0] S_MAP  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]  r_state;
    logic [3:0]  r_prev_state;
    logic [23:0] r_in_color;
    logic [23:0] r_color;
    logic [F:0]  r_peak;
    logic        r_dir;
    logic [15:0] r_step;
    logic [15:0] r_floor;
    logic [2:0]  r_sector;
    logic [7:0]  r_rem;
    logic [F:0]  r_frac;
    logic [F:0]  r_sat;
    logic [F:0]  r_v;
    logic [F:0]  r_m1;
    logic [F:0]  r_m2;
    logic [F:0]  r_p;
    logic [F:0]  r_q;
    logic [F:0]  r_t;
    logic        r_ovalid;
    hbl_pkg::t_out_word r_oword;

    logic              w_go;

    logic [23:0]       w_src;
    logic [7:0]        w_r;
    logic [7:0]        w_g;
    logic [7:0]        w_b;
    logic [7:0]        w_cmax;
    logic [7:0]        w_cmin;
    logic [7:0]        w_delta;
    logic signed [11:0] w_tots;
    logic [10:0]       w_tot;

    logic              w_div_start;
    logic [DW-1:0]     w_div_num;
    logic [7:0]        w_div_den;
    logic              w_div_done;
    logic [DW-1:0]     w_div_quo;
    logic [7:0]        w_div_rem;

    logic              w_mul_start;
    logic [F:0]        w_mul_a;
    logic [F:0]        w_mul_b;
    logic              w_mul_done;
    logic [2*F+1:0]    w_mul_prod;
    logic [F:0]        w_mres;

    logic [F+15:0]     w_step_ext;
    logic [F+15:0]     w_floor_ext;
    logic [F+1:0]      w_step;
    logic [F+1:0]      w_floor;
    logic [F+1:0]      w_sum;

    logic [F:0]        w_vr;
    logic [F:0]        w_vg;
    logic [F:0]        w_vb;

    function automatic logic [7:0] to_chan(input logic [F:0] x);
        logic [F+8:0] t;
        t = {x, 8'd0} - {8'd0, x} + {9'd0, 1'b1, {(F-1){1'b0}}};
        return (t[F+8:F] > 9'd255) ? 8'd255 : t[F+7:F];
    endfunction

    // first cycle in a new state
    assign w_go = (r_state != r_prev_state);

    always_comb begin
        w_src   = (r_state == S_PEAK) ? r_in_color : r_color;
        w_r     = w_src[23:16];
        w_g     = w_src[15:8];
        w_b     = w_src[7:0];
        w_cmax  = (w_r > w_g) ? w_r : w_g;
        w_cmax  = (w_cmax > w_b) ? w_cmax : w_b;
        w_cmin  = (w_r < w_g) ? w_r : w_g;
        w_cmin  = (w_cmin < w_b) ? w_cmin : w_b;
        w_delta = w_cmax - w_cmin;
        if (w_cmax == w_r) begin
            w_tots = $signed({4'd0, w_g}) - $signed({4'd0, w_b});
            if (w_tots < 0) begin
                w_tots = w_tots + $signed({1'b0, w_delta, 3'd0}) - $signed({3'd0, w_delta, 1'b0});
            end
        end else if (w_cmax == w_g) begin
            w_tots = $signed({3'd0, w_delta, 1'b0}) + $signed({4'd0, w_b})
                   - $signed({4'd0, w_r});
        end else begin
            w_tots = $signed({2'd0, w_delta, 2'd0}) + $signed({4'd0, w_r})
                   - $signed({4'd0, w_g});
        end
        w_tot = w_tots[10:0];
    end

    always_comb begin
        w_div_num = '0;
        w_div_den = hbl_pkg::HBL_DEN_255;
        case (r_state)
            S_PEAK, S_VAL: begin
                w_div_num = {w_cmax, {F{1'b0}}} + {{F{1'b0}}, hbl_pkg::HBL_HALF_255};
            end
            S_HUE: begin
                w_div_num = {{(DW-11){1'b0}}, w_tot};
                w_div_den = w_delta;
            end
            S_FRAC: begin
                w_div_num = {r_rem, {F{1'b0}}} + {{F{1'b0}}, 1'b0, w_delta[7:1]};
                w_div_den = w_delta;
            end
            S_SAT: begin
                w_div_num = {w_delta, {F{1'b0}}} + {{F{1'b0}}, 1'b0, w_cmax[7:1]};
                w_div_den = w_cmax;
            end
            default: begin
                w_div_num = '0;
            end
        endcase
    end

    assign w_div_start = w_go && ((r_state == S_PEAK) || (r_state == S_VAL)
                       || (r_state == S_FRAC)
                       || ((r_state == S_HUE) && (w_delta != 8'd0))
                       || ((r_state == S_SAT) && (w_cmax != 8'd0)));

    always_comb begin
        w_mul_a = r_v;
        w_mul_b = ONE - r_sat;
        case (r_state)
            S_M1: begin
                w_mul_a = r_frac;
                w_mul_b = r_sat;
            end
            S_M2: begin
                w_mul_a = ONE - r_frac;
                w_mul_b = r_sat;
            end
            S_MQ: w_mul_b = ONE - r_m1;
            S_MT: w_mul_b = ONE - r_m2;
            default: w_mul_b = ONE - r_sat;
        endcase
    end

    assign w_mul_start = w_go && ((r_state == S_M1) || (r_state == S_M2)
                       || (r_state == S_MP) || (r_state == S_MQ) || (r_state == S_MT));
    assign w_mres      = w_mul_prod[2*F:F];

    assign w_step_ext  = {r_step, {F{1'b0}}};
    assign w_floor_ext = {r_floor, {F{1'b0}}};
    assign w_step      = {2'b00, w_step_ext[F+15:16]};
    assign w_floor     = {2'b00, w_floor_ext[F+15:16]};
    assign w_sum       = {1'b0, r_v} + w_step;

    always_comb begin
        case (r_sector)
            3'd0: begin w_vr = r_v; w_vg = r_t; w_vb = r_p; end
            3'd1: begin w_vr = r_q; w_vg = r_v; w_vb = r_p; end
            3'd2: begin w_vr = r_p; w_vg = r_v; w_vb = r_t; end
            3'd3: begin w_vr = r_p; w_vg = r_q; w_vb = r_v; end
            3'd4: begin w_vr = r_t; w_vg = r_p; w_vb = r_v; end
            default: begin w_vr = r_v; w_vg = r_p; w_vb = r_q; end
        endcase
    end

    hbl_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    hbl_mul #(.W(F + 1)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_state <= S_IDLE;
            r_color      <= '0;
            r_peak       <= '0;
            r_dir        <= 1'b0;
            r_step       <= hbl_pkg::HBL_STEP_RESET;
            r_floor      <= hbl_pkg::HBL_FLOOR_RESET;
            r_ovalid     <= 1'b0;
        end else begin
            r_prev_state <= r_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hbl_pkg::HBL_REG_STEP:  r_step  <= i_cfg_data;
                    hbl_pkg::HBL_REG_FLOOR: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_out_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_color <= i_in_word.color;
                        r_state    <= i_in_word.mode ? S_HUE : S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (w_div_done) begin
                        r_peak  <= w_div_quo[F:0];
                        r_color <= r_in_color;
                        r_state <= S_OUT;
                    end
                end
                S_HUE: begin
                    if (w_go && (w_delta == 8'd0)) begin
                        r_sector <= 3'd0;
                        r_frac   <= '0;
                        r_state  <= S_SAT;
                    end else if (w_div_done) begin
                        r_sector <= w_div_quo[2:0];
                        r_rem    <= w_div_rem;
                        r_state  <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (w_div_done) begin
                        r_frac  <= w_div_quo[F:0];
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (w_go && (w_cmax == 8'd0)) begin
                        r_sat   <= '0;
                        r_state <= S_VAL;
                    end else if (w_div_done) begin
                        r_sat   <= w_div_quo[F:0];
                        r_state <= S_VAL;
                    end
                end
                S_VAL: begin
                    if (w_div_done) begin
                        r_v     <= w_div_quo[F:0];
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_dir) begin
                        if (w_sum >= {1'b0, r_peak}) begin
                            r_v   <= r_peak;
                            r_dir <= 1'b0;
                        end else begin
                            r_v <= w_sum[F:0];
                        end
                    end else begin
                        if ({1'b0, r_v} <= w_step) begin
                            r_v   <= w_floor[F:0];
                            r_dir <= 1'b1;
                        end else begin
                            r_v <= r_v - w_step[F:0];
                        end
                    end
                    r_state <= S_M1;
                end
                S_M1: begin
                    if (w_mul_done) begin
                        r_m1    <= w_mres;
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (w_mul_done) begin
                        r_m2    <= w_mres;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    if (w_mul_done) begin
                        r_p     <= w_mres;
                        r_state <= S_MQ;
                    end
                end
                S_MQ: begin
                    if (w_mul_done) begin
                        r_q     <= w_mres;
                        r_state <= S_MT;
                    end
                end
                S_MT: begin
                    if (w_mul_done) begin
                        r_t     <= w_mres;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_color <= {to_chan(w_vr), to_chan(w_vg), to_chan(w_vb)};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid       <= 1'b1;
                        r_oword.red    <= r_color[23:16];
                        r_oword.green  <= r_color[15:8];
                        r_oword.blue   <= r_color[7:0];
                        r_oword.rising <= r_dir;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== tb/hsv_breathing_led_color_checker.sv =====
// Checker for the HSV breathing LED engine: tracks config, predicts and compares output words.
module hsv_breathing_led_color_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  hbl_pkg::t_in_word                 i_in_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  hbl_pkg::t_out_word                i_out_word,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [hbl_pkg::HBL_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int F = hbl_pkg::HBL_FRACTION_BITS;
    localparam logic [63:0] ONE = 64'd1 << F;

    logic [23:0]        led_color;
    logic [63:0]        peak_v;
    logic               going_up;
    logic [15:0]        step_reg;
    logic [15:0]        floor_reg;
    hbl_pkg::t_out_word color_q[$];

    function automatic logic [63:0] scale16(logic [15:0] x);
        return ({48'd0, x} << F) >> 16;
    endfunction

    function automatic logic [63:0] fdiv(logic [63:0] num, logic [63:0] den);
        return ((num << F) + den / 2) / den;
    endfunction

    function automatic logic [7:0] chan(logic [63:0] x);
        logic [63:0] c;
        c = (x * 64'd255 + ONE / 2) >> F;
        return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    function automatic logic [7:0] max3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [7:0] min3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    task automatic breathe();
        int r, g, b, cmax, cmin, d, tot, sector;
        logic [63:0] fr, sat, v, stp, p, q, t, vr, vg, vb;
        r = int'(led_color[23:16]); g = int'(led_color[15:8]); b = int'(led_color[7:0]);
        cmax = int'(max3(led_color[23:16], led_color[15:8], led_color[7:0]));
        cmin = int'(min3(led_color[23:16], led_color[15:8], led_color[7:0]));
        d = cmax - cmin;
        sector = 0; fr = 0; sat = 0;
        if (d != 0) begin
            if (cmax == r) begin
                tot = g - b;
                if (tot < 0) tot += 6 * d;
            end else if (cmax == g) begin
                tot = 2 * d + b - r;
            end else begin
                tot = 4 * d + r - g;
            end
            sector = tot / d;
            fr = fdiv(64'(tot % d), 64'(d));
        end
        if (cmax != 0) sat = fdiv(64'(cmax - cmin), 64'(cmax));
        v = fdiv(64'(cmax), 64'd255);
        stp = scale16(step_reg);
        if (going_up) begin
            v += stp;
            if (v >= peak_v) begin
                v = peak_v;
                going_up = 1'b0;
            end
        end else if (v <= stp) begin
            v = scale16(floor_reg);
            going_up = 1'b1;
        end else begin
            v -= stp;
        end
        p = (v * (ONE - sat)) >> F;
        q = (v * (ONE - ((fr * sat) >> F))) >> F;
        t = (v * (ONE - (((ONE - fr) * sat) >> F))) >> F;
        case (sector)
            0: begin vr = v; vg = t; vb = p; end
            1: begin vr = q; vg = v; vb = p; end
            2: begin vr = p; vg = v; vb = t; end
            3: begin vr = p; vg = q; vb = v; end
            4: begin vr = t; vg = p; vb = v; end
            default: begin vr = v; vg = p; vb = q; end
        endcase
        led_color = {chan(vr), chan(vg), chan(vb)};
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        hbl_pkg::t_out_word w;
        hbl_pkg::t_out_word e;
        if (!i_rst_n) begin
            led_color = '0;
            peak_v    = '0;
            going_up  = 1'b0;
            step_reg  = hbl_pkg::HBL_STEP_RESET;
            floor_reg = hbl_pkg::HBL_FLOOR_RESET;
            color_q.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == hbl_pkg::HBL_REG_STEP) step_reg = i_cfg_data;
                else if (i_cfg_index == hbl_pkg::HBL_REG_FLOOR) floor_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_in_word.mode) begin
                    led_color = i_in_word.color;
                    peak_v = fdiv(64'(max3(led_color[23:16], led_color[15:8],
                                           led_color[7:0])), 64'd255);
                end else begin
                    breathe();
                end
                w = '{led_color[23:16], led_color[15:8], led_color[7:0], going_up};
                color_q.push_back(w);
            end
            if (i_out_valid && i_out_ready) begin
                if (color_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    e = color_q.pop_front();
                    if (i_out_word.red !== e.red) report("red", i_out_word.red, e.red);
                    if (i_out_word.green !== e.green)
                        report("green", i_out_word.green, e.green);
                    if (i_out_word.blue !== e.blue) report("blue", i_out_word.blue, e.blue);
                    if (i_out_word.rising !== e.rising)
                        report("rising", i_out_word.rising, e.rising);
                end
            end
        end
        o_pending = color_q.size();
    end
endmodule

// ===== tb/hsv_breathing_led_color_top_tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the HSV breathing LED engine.
module hsv_breathing_led_color_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hbl_pkg::HBL_CFG_IDX_W-1:0] UNUSED_REG = 8'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hbl_pkg::t_in_word  in_word;
    logic        out_valid;
    logic        out_ready;
    hbl_pkg::t_out_word out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [hbl_pkg::HBL_CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          hold_cycles;
    int          stall_mode;

    hsv_breathing_led_color_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    hsv_breathing_led_color_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: own stall pattern plus a long hold-off on request
    initial begin
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // valid stays high after acceptance only until the next word or an idle gap
    task automatic send(logic mode, logic [23:0] color);
        in_valid <= 1'b1;
        in_word  <= '{mode, color};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [hbl_pkg::HBL_CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic random_run(int count);
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (n < count) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send(1'b0, 24'($urandom));
                    end else begin
                        send(1'b1, 24'($urandom));
                    end
                    n++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    logic [15:0] step_set[5]  = '{16'd655, 16'd1, 16'd65535, 16'd9000, 16'd0};
    logic [15:0] floor_set[5] = '{16'd655, 16'd65535, 16'd1, 16'd30000, 16'd0};

    initial begin
        logic [23:0] edge_colors[12];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_cycles = 0;
        stall_mode = 0;
        edge_colors = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
                        24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010203,
                        24'hFE01FF, 24'h7F8081};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ticks from black, every edge color, some breathing
        send(1'b1, 24'h0);
        send(1'b1, 24'hFFFFFF);
        foreach (edge_colors[i]) begin
            send(1'b0, edge_colors[i]);
            send(1'b1, 24'h0);
        end
        // load lower peak while falling
        send(1'b0, 24'h200010);
        drain();

        for (int s = 0; s < 5; s++) begin
            write_reg(hbl_pkg::HBL_REG_STEP, step_set[s]);
            write_reg(hbl_pkg::HBL_REG_FLOOR, floor_set[s]);
            write_reg(UNUSED_REG, 16'($urandom));
            cfg_valid <= 1'b0;
            stall_mode = s % 3;
            if (s == 1) begin
                hold_cycles = 2000;
            end
            random_run(190);
            drain();
        end
        write_reg(hbl_pkg::HBL_REG_STEP, 16'($urandom_range(1, 65535)));
        write_reg(hbl_pkg::HBL_REG_FLOOR, 16'($urandom_range(1, 65535)));
        cfg_valid <= 1'b0;
        random_run(60);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== hsv_breathing_led_color_top.f =====
rtl/core/hbl_pkg.sv
rtl/core/hbl_div.sv
rtl/core/hbl_mul.sv
rtl/core/hsv_breathing_led_color_top.sv
tb/hsv_breathing_led_color_checker.sv
tb/hsv_breathing_led_color_top_tb.sv
